FILE: src/assert_macros.svh
// Assertion macros shared by the frame engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMP(label, ant, con, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NXT(label, ant, con, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

FILE: src/mbrtu_pkg.sv
// Package: item types, codes, constants and the CRC-16/MODBUS byte update.
`timescale 1ns / 1ps

package mbrtu_pkg;

    localparam int unsigned MBRTU_MAX_PAYLOAD = 255;
    localparam int unsigned MAX_RESULTS       = 5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;
    localparam logic [7:0] FUNC_CODE_RST  = 8'd109;

    typedef enum logic [1:0] {
        IK_TX_START = 2'd0,
        IK_TX_BYTE  = 2'd1,
        IK_RX_BYTE  = 2'd2,
        IK_TICK     = 2'd3
    } in_kind_t;

    typedef enum logic [1:0] {
        OK_WIRE    = 2'd0,
        OK_PAYLOAD = 2'd1,
        OK_STATUS  = 2'd2
    } out_kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TIMEOUT      = 3'd1,
        ST_WRONG_ADDR   = 3'd2,
        ST_WRONG_FUNC   = 3'd3,
        ST_BAD_LENGTH   = 3'd4,
        ST_CRC_MISMATCH = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TX   = 3'd1,
        PH_RXH  = 3'd2,
        PH_RXP  = 3'd3,
        PH_RXC  = 3'd4
    } phase_t;

    typedef enum logic {
        REG_SLAVE_ADDR = 1'b0,
        REG_FUNC_CODE  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [15:0] response_timeout;
    } in_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } out_item_t;

    // One queued result, before the last flag is attached.
    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [2:0] status;
    } result_t;

    // Reflected CRC-16/MODBUS, one byte, LSB first.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    localparam logic [15:0] CRC_ADDR_RST = crc16_update(CRC_INIT, SLAVE_ADDR_RST);
    localparam logic [15:0] CRC_HDR_RST  = crc16_update(CRC_ADDR_RST, FUNC_CODE_RST);

endpackage

FILE: src/mbrtu_stream_if.sv
// Interface: valid/ready channel carrying one item payload.
`timescale 1ns / 1ps

interface mbrtu_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/modbus_rtu_tunnel_frame_engine_top.sv
// Top level: Modbus RTU tunnel frame engine (request framing, response check, CRC).
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   ingress (sink, in_item_t): transmit start, transmit payload byte, received
//   byte or millisecond tick. egress (source, out_item_t): wire bytes, received
//   payload bytes and the closing receive status; last marks the final result
//   of one input item. cfg_we/cfg_index/cfg_data write the slave address
//   (index 0) and the function code (index 1); write them only while idle.
// Path: an accepted item lands in the input register; once the queue drains, its
//   results (0 to 5) are loaded into the result queue and the first one is
//   offered on egress at once, straight from queue entry 0.
// Throughput: one input item per cycle while each item gives at most one result
//   and egress is ready; an item with n results holds the queue until all n are
//   taken. The rate is set by the single egress port draining the result queue.
// Reset: phase idle, CRC 0xFFFF, counters and timeout zero, registers at
//   address 1 and function code 109; queue and input register empty.
// Stall: when egress is not ready, the queue holds; one more item is still
//   taken into the input register, then ingress.ready drops.
module modbus_rtu_tunnel_frame_engine_top
    import mbrtu_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MBRTU_MAX_PAYLOAD
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mbrtu_stream_if.sink          ingress,
    mbrtu_stream_if.source        egress,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [7:0]            cfg_data
);

    localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);
    localparam int unsigned QW    = $clog2(MAX_RESULTS + 1);

    // Configuration and the precomputed CRC over address and function code.
    logic [7:0]  slave_addr_reg;
    logic [7:0]  func_code_reg;
    logic [15:0] crc_addr_reg;
    logic [15:0] crc_hdr_reg;
    logic [15:0] cfg_addr_crc;

    // Input register.
    in_item_t    in_reg;
    logic        in_valid_reg;

    // Exchange state.
    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  flen_reg, flen_next;
    logic [15:0] tmo_reg, tmo_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    // Result queue: entry 0 is offered on egress.
    result_t     batch_reg [MAX_RESULTS];
    result_t     batch_next [MAX_RESULTS];
    logic [QW-1:0] rem_reg, rem_next;

    logic        advance;
    logic        out_fire;
    logic [7:0]  tx_len;
    logic [7:0]  upd_byte;
    logic [15:0] upd_base;
    logic [15:0] crc_upd;
    logic [7:0]  cnt_inc;
    logic [15:0] tmo_dec;

    // Move the held item into the queue once the queue drains this cycle.
    assign out_fire      = egress.valid && egress.ready;
    assign advance       = in_valid_reg &&
                           ((rem_reg == '0) || ((rem_reg == QW'(1)) && egress.ready));
    assign ingress.ready = !in_valid_reg || advance;

    assign egress.valid            = (rem_reg != '0);
    assign egress.payload.out_kind = batch_reg[0].out_kind;
    assign egress.payload.out_byte = batch_reg[0].out_byte;
    assign egress.payload.status   = batch_reg[0].status;
    assign egress.payload.last     = (rem_reg == QW'(1));

    assign cfg_addr_crc = crc16_update(CRC_INIT, cfg_data);

    // Configuration registers; refresh the header CRC together with the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= SLAVE_ADDR_RST;
            func_code_reg  <= FUNC_CODE_RST;
            crc_addr_reg   <= CRC_ADDR_RST;
            crc_hdr_reg    <= CRC_HDR_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_SLAVE_ADDR:
                    begin
                        slave_addr_reg <= cfg_data;
                        crc_addr_reg   <= cfg_addr_crc;
                        crc_hdr_reg    <= crc16_update(cfg_addr_crc, func_code_reg);
                    end
                    REG_FUNC_CODE:
                    begin
                        func_code_reg <= cfg_data;
                        crc_hdr_reg   <= crc16_update(crc_addr_reg, cfg_data);
                    end
                    default:        ;
                endcase
            end
        end
    end

    // Shared byte update: the length on a start, else the data byte.
    always_comb
    begin
        tx_len   = (in_reg.value > MaxLen) ? MaxLen : in_reg.value;
        upd_base = (in_reg.kind == IK_TX_START) ? crc_hdr_reg : crc_reg;
        upd_byte = (in_reg.kind == IK_TX_START) ? tx_len : in_reg.value;
        crc_upd  = crc16_update(upd_base, upd_byte);
        cnt_inc  = count_reg + 8'd1;
        tmo_dec  = (tmo_reg != 16'd0) ? (tmo_reg - 16'd1) : 16'd0;
    end

    // Next state and the result list of the held item.
    always_comb
    begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        count_next  = count_reg;
        flen_next   = flen_reg;
        tmo_next    = tmo_reg;
        crc_lo_next = crc_lo_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            batch_next[i] = '0;
        end
        rem_next = '0;

        unique case (in_kind_t'(in_reg.kind))
            IK_TX_START:
            begin
                batch_next[0] = '{OK_WIRE, slave_addr_reg, ST_OK};
                batch_next[1] = '{OK_WIRE, func_code_reg, ST_OK};
                batch_next[2] = '{OK_WIRE, tx_len, ST_OK};
                flen_next     = tx_len;
                count_next    = 8'd0;
                tmo_next      = in_reg.response_timeout;
                if (tx_len == 8'd0)
                begin
                    batch_next[3] = '{OK_WIRE, crc_upd[7:0], ST_OK};
                    batch_next[4] = '{OK_WIRE, crc_upd[15:8], ST_OK};
                    rem_next      = QW'(5);
                    crc_next      = CRC_INIT;
                    phase_next    = PH_RXH;
                end
                else
                begin
                    rem_next   = QW'(3);
                    crc_next   = crc_upd;
                    phase_next = PH_TX;
                end
            end
            IK_TX_BYTE:
            begin
                if (phase_reg == PH_TX)
                begin
                    batch_next[0] = '{OK_WIRE, in_reg.value, ST_OK};
                    if (cnt_inc >= flen_reg)
                    begin
                        batch_next[1] = '{OK_WIRE, crc_upd[7:0], ST_OK};
                        batch_next[2] = '{OK_WIRE, crc_upd[15:8], ST_OK};
                        rem_next      = QW'(3);
                        crc_next      = CRC_INIT;
                        count_next    = 8'd0;
                        phase_next    = PH_RXH;
                    end
                    else
                    begin
                        rem_next   = QW'(1);
                        crc_next   = crc_upd;
                        count_next = cnt_inc;
                    end
                end
            end
            IK_RX_BYTE:
            begin
                case (phase_reg)
                    PH_RXH:
                    begin
                        crc_next = crc_upd;
                        if (count_reg == 8'd0)
                        begin
                            if (in_reg.value != slave_addr_reg)
                            begin
                                batch_next[0] = '{OK_STATUS, 8'd0, ST_WRONG_ADDR};
                                rem_next      = QW'(1);
                                phase_next    = PH_IDLE;
                            end
                            else
                            begin
                                count_next = 8'd1;
                            end
                        end
                        else if (count_reg == 8'd1)
                        begin
                            if (in_reg.value != func_code_reg)
                            begin
                                batch_next[0] = '{OK_STATUS, 8'd0, ST_WRONG_FUNC};
                                rem_next      = QW'(1);
                                phase_next    = PH_IDLE;
                            end
                            else
                            begin
                                count_next = 8'd2;
                            end
                        end
                        else if ((in_reg.value == 8'd0) || (in_reg.value > MaxLen))
                        begin
                            batch_next[0] = '{OK_STATUS, 8'd0, ST_BAD_LENGTH};
                            rem_next      = QW'(1);
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            flen_next  = in_reg.value;
                            count_next = 8'd0;
                            phase_next = PH_RXP;
                        end
                    end
                    PH_RXP:
                    begin
                        crc_next      = crc_upd;
                        batch_next[0] = '{OK_PAYLOAD, in_reg.value, ST_OK};
                        rem_next      = QW'(1);
                        if (cnt_inc >= flen_reg)
                        begin
                            count_next = 8'd0;
                            phase_next = PH_RXC;
                        end
                        else
                        begin
                            count_next = cnt_inc;
                        end
                    end
                    PH_RXC:
                    begin
                        if (count_reg == 8'd0)
                        begin
                            crc_lo_next = in_reg.value;
                            count_next  = 8'd1;
                        end
                        else
                        begin
                            batch_next[0] = ({in_reg.value, crc_lo_reg} == crc_reg) ?
                                            '{OK_STATUS, 8'd0, ST_OK} :
                                            '{OK_STATUS, 8'd0, ST_CRC_MISMATCH};
                            rem_next      = QW'(1);
                            phase_next    = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            IK_TICK:
            begin
                // Count down only while a response is awaited.
                if ((phase_reg == PH_RXH) || (phase_reg == PH_RXP) || (phase_reg == PH_RXC))
                begin
                    tmo_next = tmo_dec;
                    if (tmo_dec == 16'd0)
                    begin
                        batch_next[0] = '{OK_STATUS, 8'd0, ST_TIMEOUT};
                        rem_next      = QW'(1);
                        phase_next    = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            rem_reg      <= '0;
            phase_reg    <= PH_IDLE;
            crc_reg      <= CRC_INIT;
            count_reg    <= 8'd0;
            flen_reg     <= 8'd0;
            tmo_reg      <= 16'd0;
            crc_lo_reg   <= 8'd0;
        end
        else
        begin
            if (ingress.ready)
            begin
                in_valid_reg <= ingress.valid;
            end
            if (advance)
            begin
                rem_reg    <= rem_next;
                phase_reg  <= phase_next;
                crc_reg    <= crc_next;
                count_reg  <= count_next;
                flen_reg   <= flen_next;
                tmo_reg    <= tmo_next;
                crc_lo_reg <= crc_lo_next;
            end
            else if (out_fire)
            begin
                rem_reg <= rem_reg - QW'(1);
            end
        end
    end

    // Payload: capture the item, load or shift the queue.
    always_ff @(posedge clk)
    begin
        if (ingress.valid && ingress.ready)
        begin
            in_reg <= ingress.payload;
        end
        if (advance)
        begin
            batch_reg <= batch_next;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                batch_reg[i] <= batch_reg[i + 1];
            end
        end
    end

    // A status item always closes its burst, and the engine is idle behind it.
    `ASSERT_IMP(a_status_closes, egress.valid && (egress.payload.out_kind == OK_STATUS),
                egress.payload.last && (phase_reg == PH_IDLE),
                "status item not last or engine not idle")

    // The queue never holds more results than one item can cause.
    `ASSERT_IMP(a_queue_bound, 1'b1, rem_reg <= QW'(MAX_RESULTS),
                "result queue overfilled")

    // The held item only moves on when the queue is draining its last result.
    `ASSERT_IMP(a_no_overwrite, advance && (rem_reg != '0),
                out_fire && egress.payload.last,
                "queue reloaded over pending results")

    // A stalled result stays offered with the same bits.
    `ASSERT_NXT(a_hold_on_stall, egress.valid && !egress.ready,
                egress.valid && $stable(rem_reg) && $stable(batch_reg[0]),
                "pending result changed under stall")

endmodule

FILE: test/tb.sv
// Testbench for the Modbus RTU tunnel frame engine: random traffic checked by a scoreboard.
`timescale 1ns / 1ps

module tb;
    import mbrtu_pkg::*;

    localparam int unsigned MAX_LEN     = MBRTU_MAX_PAYLOAD;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_ITEMS = 58;
    localparam int          SETTLE      = 8;

    // Shape of the response that the stimulus plays back after a request.
    typedef enum int {
        RP_OK,
        RP_CRC_BAD,
        RP_WRONG_ADDR,
        RP_WRONG_FUNC,
        RP_BAD_LEN,
        RP_SILENT
    } reply_t;

    // Frame engine predictor plus the store of the results it still expects.
    class frame_scoreboard;
        out_item_t   expected_q[$];
        out_item_t   fresh[$];
        logic [7:0]  slave_addr;
        logic [7:0]  func_code;
        phase_t      ph;
        logic [15:0] crc;
        logic [7:0]  count;
        logic [7:0]  frame_len;
        logic [15:0] ms_left;
        logic [7:0]  crc_low;
        int          mismatches;
        int          useful;
        int          checked;

        function new();
            slave_addr = SLAVE_ADDR_RST;
            func_code  = FUNC_CODE_RST;
            ph         = PH_IDLE;
            crc        = 16'hFFFF;
            count      = '0;
            frame_len  = '0;
            ms_left    = '0;
            crc_low    = '0;
            mismatches = 0;
            useful     = 0;
            checked    = 0;
        endfunction

        static function logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] b);
            logic [15:0] r;
            r = acc ^ {8'h00, b};
            repeat (8) r = (r >> 1) ^ (16'hA001 & {16{r[0]}});
            return r;
        endfunction

        function void set_reg(reg_index_t idx, logic [7:0] d);
            if (idx == REG_SLAVE_ADDR)
                slave_addr = d;
            else
                func_code = d;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push(out_kind_t k, logic [7:0] b, status_t st);
            out_item_t r;
            r.out_kind = k;
            r.out_byte = b;
            r.status   = st;
            r.last     = 1'b0;
            fresh.push_back(r);
        endfunction

        function void push_wire(logic [7:0] b);
            crc = crc_byte(crc, b);
            push(OK_WIRE, b, ST_OK);
        endfunction

        function void close_exchange(status_t st);
            push(OK_STATUS, 8'h00, st);
            ph = PH_IDLE;
        endfunction

        // Append the request CRC, low byte first, and turn around to listen.
        function void open_receive();
            logic [15:0] sum;
            sum = crc;
            push(OK_WIRE, sum[7:0], ST_OK);
            push(OK_WIRE, sum[15:8], ST_OK);
            crc   = 16'hFFFF;
            count = '0;
            ph    = PH_RXH;
        endfunction

        function void note_input(in_kind_t k, logic [7:0] v, logic [15:0] tmo);
            logic [7:0] len;
            bit         listening;
            fresh     = {};
            listening = (ph == PH_RXH) || (ph == PH_RXP) || (ph == PH_RXC);
            case (k)
                IK_TX_START: begin
                    useful++;
                    len = (v > MAX_LEN) ? 8'(MAX_LEN) : v;
                    crc = 16'hFFFF;
                    push_wire(slave_addr);
                    push_wire(func_code);
                    push_wire(len);
                    frame_len = len;
                    count     = '0;
                    ms_left   = tmo;
                    if (len == 0)
                        open_receive();
                    else
                        ph = PH_TX;
                end
                IK_TX_BYTE: begin
                    if (ph == PH_TX)
                    begin
                        useful++;
                        push_wire(v);
                        count++;
                        if (count >= frame_len)
                            open_receive();
                    end
                end
                IK_RX_BYTE: begin
                    if (listening)
                        useful++;
                    if (ph == PH_RXH)
                    begin
                        crc = crc_byte(crc, v);
                        if (count == 0)
                        begin
                            if (v != slave_addr)
                                close_exchange(ST_WRONG_ADDR);
                            else
                                count = 1;
                        end
                        else if (count == 1)
                        begin
                            if (v != func_code)
                                close_exchange(ST_WRONG_FUNC);
                            else
                                count = 2;
                        end
                        else if (v == 0 || v > MAX_LEN)
                            close_exchange(ST_BAD_LENGTH);
                        else
                        begin
                            frame_len = v;
                            count     = '0;
                            ph        = PH_RXP;
                        end
                    end
                    else if (ph == PH_RXP)
                    begin
                        crc = crc_byte(crc, v);
                        push(OK_PAYLOAD, v, ST_OK);
                        count++;
                        if (count >= frame_len)
                        begin
                            count = '0;
                            ph    = PH_RXC;
                        end
                    end
                    else if (ph == PH_RXC)
                    begin
                        if (count == 0)
                        begin
                            crc_low = v;
                            count   = 1;
                        end
                        else
                            close_exchange(({v, crc_low} == crc) ? ST_OK : ST_CRC_MISMATCH);
                    end
                end
                default: begin
                    if (listening)
                    begin
                        useful++;
                        if (ms_left != 0)
                            ms_left--;
                        if (ms_left == 0)
                            close_exchange(ST_TIMEOUT);
                    end
                end
            endcase
            if (fresh.size() > 0)
            begin
                fresh[fresh.size() - 1].last = 1'b1;
                foreach (fresh[i])
                    expected_q.push_back(fresh[i]);
            end
        endfunction

        function void note_error(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s", $time, what);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                note_error($sformatf({"result %0d with nothing expected: ",
                                      "kind=%0d byte=%02h st=%0d last=%0b"},
                                     checked, got.out_kind, got.out_byte, got.status,
                                     got.last));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
                got.status !== want.status || got.last !== want.last)
                note_error($sformatf({"result %0d: expected kind=%0d byte=%02h st=%0d ",
                                      "last=%0b, got kind=%0d byte=%02h st=%0d last=%0b"},
                                     checked, want.out_kind, want.out_byte, want.status,
                                     want.last, got.out_kind, got.out_byte, got.status,
                                     got.last));
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic            cfg_index;
    logic [7:0]      cfg_data;
    bit              burst;
    int              cycles;
    frame_scoreboard book;

    mbrtu_stream_if #(.payload_t(in_item_t))  ingress ();
    mbrtu_stream_if #(.payload_t(out_item_t)) egress ();

    modbus_rtu_tunnel_frame_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ingress   (ingress),
        .egress    (egress),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a correct run finishes far below this count.
    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Check every result item taken from the egress channel.
    always @(posedge clk)
    begin
        if (rst_n && egress.valid && egress.ready)
            book.check_result(egress.payload);
    end

    // Receiver: stall a random number of cycles before taking each result item,
    // except during burst stretches, where results are drained back to back.
    initial
    begin
        int stall;
        egress.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = burst ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                egress.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            egress.ready <= 1'b1;
            do @(posedge clk); while (!egress.valid);
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom_range(0, 65535));
    endfunction

    // Offer one item after a random gap and hold it until the engine takes it.
    // Called and returning at a falling edge.
    task automatic send_item(in_kind_t k, logic [7:0] v, logic [15:0] t);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            ingress.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ingress.valid   <= 1'b1;
        ingress.payload <= '{kind: k, value: v, response_timeout: t};
        do @(posedge clk); while (!ingress.ready);
        book.note_input(k, v, t);
        @(negedge clk);
    endtask

    // Drop valid, wait out every expected result, then let the pipeline settle
    // so that items without results are fully absorbed too.
    task automatic drain();
        ingress.valid <= 1'b0;
        while (book.pending() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write the slave address and then the function code on consecutive edges; only called while drained.
    task automatic write_regs(logic [7:0] addr, logic [7:0] func);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SLAVE_ADDR;
        cfg_data  <= addr;
        @(negedge clk);
        book.set_reg(REG_SLAVE_ADDR, addr);
        cfg_index <= REG_FUNC_CODE;
        cfg_data  <= func;
        @(negedge clk);
        book.set_reg(REG_FUNC_CODE, func);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // A stray item of a kind that is ignored while idle.
    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            send_item(IK_TX_BYTE, rnd8(), rnd16());
        else if (pick == 1)
            send_item(IK_RX_BYTE, rnd8(), rnd16());
        else
            send_item(IK_TICK, rnd8(), rnd16());
    endtask

    function automatic reply_t draw_reply();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return RP_OK;
        else if (pick < 60)
            return RP_CRC_BAD;
        else if (pick < 68)
            return RP_WRONG_ADDR;
        else if (pick < 76)
            return RP_WRONG_FUNC;
        else if (pick < 84)
            return RP_BAD_LEN;
        return RP_SILENT;
    endfunction

    // One request/response exchange with random content. Half the drawn replies are
    // well formed; the rest are cut short or corrupted, and some are salted with stray items.
    task automatic run_exchange();
        reply_t      reply;
        int          pick;
        int          tx_len;
        int          rx_len;
        int          keep;
        logic [15:0] tmo;
        logic [15:0] sum;
        logic [7:0]  frame[$];

        burst = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 4) == 0)
            send_noise();

        reply  = draw_reply();
        pick   = $urandom_range(0, 99);
        tx_len = (pick < 20) ? 0 : (pick < 85) ? $urandom_range(1, 6) : $urandom_range(7, 30);
        tmo    = (reply == RP_SILENT) ? 16'($urandom_range(0, 3)) : rnd16();

        send_item(IK_TX_START, 8'(tx_len), tmo);
        for (int i = 0; i < tx_len; i++)
        begin
            // Received bytes and ticks are ignored while the request goes out.
            if ($urandom_range(0, 19) == 0)
                send_item($urandom_range(0, 1) ? IK_RX_BYTE : IK_TICK, rnd8(), rnd16());
            send_item(IK_TX_BYTE, rnd8(), rnd16());
        end
        // Leave the exchange hanging now and then; the next start abandons it.
        if ($urandom_range(0, 15) == 0)
            return;

        rx_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        frame  = {book.slave_addr, book.func_code, 8'(rx_len)};
        for (int i = 0; i < rx_len; i++)
            frame.push_back(rnd8());

        keep = -1;
        case (reply)
            RP_WRONG_ADDR: begin
                frame[0] ^= 8'($urandom_range(1, 255));
                keep = 1;
            end
            RP_WRONG_FUNC: begin
                frame[1] ^= 8'($urandom_range(1, 255));
                keep = 2;
            end
            RP_BAD_LEN: begin
                frame[2] = 8'h00;
                keep = 3;
            end
            RP_SILENT:
                keep = $urandom_range(0, 2);
            default: ;
        endcase

        sum = 16'hFFFF;
        foreach (frame[i])
            sum = frame_scoreboard::crc_byte(sum, frame[i]);
        if (reply == RP_CRC_BAD)
            sum ^= 16'($urandom_range(1, 65535));
        frame.push_back(sum[7:0]);
        frame.push_back(sum[15:8]);

        // Header errors: half the time send the rest of the frame anyway; the
        // engine is idle by then and must ignore it.
        if (keep >= 0 && (reply == RP_SILENT || $urandom_range(0, 1) == 0))
            while (frame.size() > keep)
                void'(frame.pop_back());

        foreach (frame[i])
        begin
            if ($urandom_range(0, 99) < 3)
                break;
            if ($urandom_range(0, 99) < 8)
                send_item(IK_TICK, rnd8(), rnd16());
            if ($urandom_range(0, 99) < 4)
                send_item(IK_TX_BYTE, rnd8(), rnd16());
            send_item(IK_RX_BYTE, frame[i], rnd16());
        end

        // Silent slave: tick until the short timeout expires.
        if (reply == RP_SILENT)
            while (book.ph != PH_IDLE)
                send_item(IK_TICK, rnd8(), rnd16());
    endtask

    // Register settings visited by the random part; extremes first.
    logic [7:0] addr_set[6];
    logic [7:0] func_set[6];

    initial
    begin
        int quota;

        book          = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SLAVE_ADDR;
        cfg_data      = 8'h00;
        burst         = 1'b0;
        ingress.valid = 1'b0;
        ingress.payload = '0;

        addr_set = '{8'h00, 8'hFF, 8'd247, 8'd1, rnd8(), rnd8()};
        func_set = '{8'h00, 8'hFF, 8'h01, 8'd109, rnd8(), rnd8()};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, registers at their reset values.
        // Stray items while idle: all ignored.
        send_item(IK_TICK, 8'hFF, 16'hFFFF);
        send_item(IK_RX_BYTE, 8'h01, 16'h0000);
        send_item(IK_TX_BYTE, 8'h00, 16'h0000);
        // Empty request: CRC right after the header, zero timeout fires on the first tick.
        send_item(IK_TX_START, 8'h00, 16'h0000);
        send_item(IK_TICK, 8'h00, 16'h0000);
        // Longest request, abandoned by a new start after two bytes.
        send_item(IK_TX_START, 8'hFF, 16'hFFFF);
        send_item(IK_TX_BYTE, 8'h00, 16'hFFFF);
        send_item(IK_TX_BYTE, 8'hFF, 16'h0000);
        send_item(IK_TX_START, 8'h01, 16'h0002);
        send_item(IK_TX_BYTE, 8'hA5, 16'h5A5A);
        // Response announces the largest length, then the timeout runs out mid-payload.
        send_item(IK_RX_BYTE, SLAVE_ADDR_RST, 16'h0000);
        send_item(IK_RX_BYTE, FUNC_CODE_RST, 16'h0000);
        send_item(IK_RX_BYTE, 8'hFF, 16'h0000);
        send_item(IK_RX_BYTE, 8'h00, 16'h0000);
        send_item(IK_TICK, 8'h00, 16'h0000);
        send_item(IK_TICK, 8'h00, 16'h0000);
        // Wrong address.
        send_item(IK_TX_START, 8'h01, 16'h0005);
        send_item(IK_TX_BYTE, 8'h5A, 16'h0000);
        send_item(IK_RX_BYTE, 8'h02, 16'h0000);
        // Wrong function code.
        send_item(IK_TX_START, 8'h00, 16'h0005);
        send_item(IK_RX_BYTE, SLAVE_ADDR_RST, 16'h0000);
        send_item(IK_RX_BYTE, 8'h6C, 16'h0000);
        // Zero response length.
        send_item(IK_TX_START, 8'h00, 16'h0005);
        send_item(IK_RX_BYTE, SLAVE_ADDR_RST, 16'h0000);
        send_item(IK_RX_BYTE, FUNC_CODE_RST, 16'h0000);
        send_item(IK_RX_BYTE, 8'h00, 16'h0000);
        drain();

        // Random part: one batch of exchanges per register setting.
        for (int s = 0; s < 6; s++)
        begin
            write_regs(addr_set[s], func_set[s]);
            quota = book.useful + PHASE_ITEMS;
            while (book.useful < quota)
                run_exchange();
            burst = 1'b0;
            drain();
        end

        if (book.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
